>>> hw/rtl/bda_pkg.sv
// Package: shared constants and codes of the deadlock-avoidance block.
package bda_pkg;

    localparam int DefMaxProcesses = 16;
    localparam int DefMaxResources = 8;
    localparam int DefCountWidth   = 16;
    localparam int OutLimit        = 16;

    localparam int OpWidth     = 3;
    localparam int ProcWidth   = 4;
    localparam int ResWidth    = 3;
    localparam int AmountWidth = 16;
    localparam int StatusWidth = 3;
    localparam int PcWidth     = 5;
    localparam int RcWidth     = 4;

    localparam logic [OpWidth-1:0] OP_LOAD_AVAIL = 3'd0;
    localparam logic [OpWidth-1:0] OP_LOAD_MAX   = 3'd1;
    localparam logic [OpWidth-1:0] OP_LOAD_ALLOC = 3'd2;
    localparam logic [OpWidth-1:0] OP_SAFETY     = 3'd3;
    localparam logic [OpWidth-1:0] OP_STAGE      = 3'd4;
    localparam logic [OpWidth-1:0] OP_COMMIT     = 3'd5;

    localparam logic [StatusWidth-1:0] ST_LOADED  = 3'd0;
    localparam logic [StatusWidth-1:0] ST_SAFE    = 3'd1;
    localparam logic [StatusWidth-1:0] ST_UNSAFE  = 3'd2;
    localparam logic [StatusWidth-1:0] ST_GRANTED = 3'd3;
    localparam logic [StatusWidth-1:0] ST_EXCEEDS = 3'd4;
    localparam logic [StatusWidth-1:0] ST_WAIT    = 3'd5;
    localparam logic [StatusWidth-1:0] ST_DENIED  = 3'd6;
    localparam logic [StatusWidth-1:0] ST_BAD     = 3'd7;

    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

endpackage

>>> hw/rtl/bda_ifs.sv
// Interfaces: input item channel and result channel.
interface bda_item_if
    import bda_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OpWidth-1:0]     operation;
    logic [ProcWidth-1:0]   process;
    logic [ResWidth-1:0]    resource;
    logic [AmountWidth-1:0] amount;

    modport source (output valid, operation, process, resource, amount, input ready);
    modport sink   (input valid, operation, process, resource, amount, output ready);
endinterface

interface bda_result_if
    import bda_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [StatusWidth-1:0] status;
    logic [ProcWidth-1:0]   sequence_process;
    logic                   last_result;

    modport source (output valid, status, sequence_process, last_result, input ready);
    modport sink   (input valid, status, sequence_process, last_result, output ready);
endinterface

>>> hw/rtl/bda_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/bankers_deadlock_avoidance.sv
// Top level: banker's deadlock avoidance over RAM-held claim and allocation tables.
// Loads and staging go straight to the result. Commit: a checking pass and a write sweep give
// the tentative grant, then a safety check, and a rollback sweep when the grant is denied.
// Safety check: up to n*n process visits; a finished process is skipped, a tested one
// is read one resource per cycle through the table RAM read port, then drained and decided.
// One transaction at a time; the next input is taken while the last result still waits.
// Reset: asynchronous, active low; counts to 16 and 8, tables read as zero until written.
module bankers_deadlock_avoidance
    import bda_pkg::*;
#(
    parameter int MAX_PROCESSES = DefMaxProcesses,
    parameter int MAX_RESOURCES = DefMaxResources,
    parameter int COUNT_WIDTH   = DefCountWidth
) (
    input  logic        clk,
    input  logic        rst_n,
    bda_item_if.sink    item,
    bda_result_if.source result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [PcWidth-1:0] wr_data
);
    localparam int EffMax = (MAX_PROCESSES < OutLimit) ? MAX_PROCESSES : OutLimit;
    localparam int NW     = $clog2(EffMax + 1);
    localparam int PW     = $clog2(MAX_PROCESSES);
    localparam int RW     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int MW     = $clog2(MAX_RESOURCES + 1);
    localparam int Depth  = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW     = $clog2(Depth);
    localparam int CW     = COUNT_WIDTH;

    typedef enum logic [3:0] {
        IDLE, EMIT, S_INIT, S_VISIT, S_PASS, S_DRAIN, S_DECIDE, S_END,
        C_PASS, C_DRAIN, C_DECIDE, C_WR, R_WR
    } state_t;

    state_t state_reg, ret_reg;

    // configuration
    logic [PcWidth-1:0] pc_reg;
    logic [RcWidth-1:0] rc_reg;
    logic [NW-1:0]      n_eff;
    logic [MW-1:0]      m_eff;

    // small vectors held in flops
    logic [CW-1:0] avail_reg  [MAX_RESOURCES];
    logic [CW-1:0] staged_reg [MAX_RESOURCES];
    logic [CW-1:0] work_reg   [MAX_RESOURCES];
    logic [CW-1:0] tmp_reg    [MAX_RESOURCES];
    logic [CW-1:0] oldal_reg  [MAX_RESOURCES];
    logic [CW-1:0] newal_reg  [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] fin_reg;
    logic [Depth-1:0] mvld_reg, avld_reg;

    // transaction and sequencer registers
    logic [ProcWidth-1:0] p_reg;
    logic                 commit_reg, cpass_reg;
    logic [PW-1:0]        i_reg;
    logic [NW-1:0]        done_reg, idle_reg;
    logic [RW-1:0]        rcnt_reg;
    logic                 fit_reg, exc_reg, wt_reg;
    logic                 pend_reg, pend_mv_reg, pend_av_reg;
    logic [RW-1:0]        pend_r_reg;

    // result register
    logic                   ov_reg, olast_reg, em_last_reg;
    logic [StatusWidth-1:0] ost_reg, em_st_reg;
    logic [ProcWidth-1:0]   oseq_reg, em_seq_reg;

    // RAM ports
    logic          max_we, al_we;
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] max_wdata, al_wdata, max_rd, al_rd;

    logic [31:0]   amt32;
    logic [CW-1:0] amt_cw;
    logic          accept, bad;
    logic          last_issue;
    logic          emit_go;
    logic [PW-1:0] row_sel;
    logic [CW-1:0] mx_v, al_v, need_v;
    logic [CW:0]   sum_v;

    function automatic logic [AW-1:0] tab_addr(input int row, input int col);
        tab_addr = AW'(row * MAX_RESOURCES + col);
    endfunction

    // clamp counts to their usable range
    always_comb
    begin
        if (pc_reg == '0)
            n_eff = NW'(1);
        else if (int'(pc_reg) > EffMax)
            n_eff = NW'(EffMax);
        else
            n_eff = NW'(pc_reg);
        if (rc_reg == '0)
            m_eff = MW'(1);
        else if (int'(rc_reg) > MAX_RESOURCES)
            m_eff = MW'(MAX_RESOURCES);
        else
            m_eff = MW'(rc_reg);
    end

    assign amt32  = 32'(item.amount);
    assign amt_cw = amt32[CW-1:0];
    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == IDLE);

    always_comb
    begin
        bad = 1'b0;
        case (item.operation)
            OP_LOAD_AVAIL: bad = int'(item.resource) >= int'(m_eff);
            OP_LOAD_MAX, OP_LOAD_ALLOC:
                bad = int'(item.resource) >= int'(m_eff) ||
                      int'(item.process) >= int'(n_eff);
            OP_SAFETY:     bad = 1'b0;
            OP_STAGE:      bad = int'(item.resource) >= int'(m_eff);
            OP_COMMIT:     bad = int'(item.process) >= int'(n_eff);
            default:       bad = 1'b1;
        endcase
    end

    assign last_issue = int'(rcnt_reg) == int'(m_eff) - 1;
    assign row_sel    = cpass_reg ? PW'(p_reg) : i_reg;
    assign raddr      = tab_addr(int'(row_sel), int'(rcnt_reg));

    // load the result register when the pending result can move in
    assign emit_go = (state_reg == EMIT) && (!ov_reg || result.ready);

    // RAM writes: loads from the input, commit and rollback sweeps from new and old alloc rows
    always_comb
    begin
        max_we    = 1'b0;
        al_we     = 1'b0;
        waddr     = tab_addr(int'(item.process), int'(item.resource));
        max_wdata = amt_cw;
        al_wdata  = amt_cw;
        if (state_reg == IDLE)
        begin
            max_we = accept && !bad && item.operation == OP_LOAD_MAX;
            al_we  = accept && !bad && item.operation == OP_LOAD_ALLOC;
        end
        else if (state_reg == C_WR || state_reg == R_WR)
        begin
            al_we    = 1'b1;
            waddr    = tab_addr(int'(p_reg), int'(rcnt_reg));
            al_wdata = (state_reg == C_WR) ? newal_reg[rcnt_reg] : oldal_reg[rcnt_reg];
        end
    end

    // returned table data; entries never written read as zero
    assign mx_v   = pend_mv_reg ? max_rd : '0;
    assign al_v   = pend_av_reg ? al_rd : '0;
    assign need_v = (mx_v > al_v) ? (mx_v - al_v) : '0;
    assign sum_v  = {1'b0, work_reg[pend_r_reg]} + {1'b0, al_v};

    bda_ram #(.WIDTH(CW), .DEPTH(Depth)) u_max_ram (
        .clk   (clk),
        .we    (max_we),
        .waddr (waddr),
        .wdata (max_wdata),
        .raddr (raddr),
        .rdata (max_rd)
    );

    bda_ram #(.WIDTH(CW), .DEPTH(Depth)) u_alloc_ram (
        .clk   (clk),
        .we    (al_we),
        .waddr (waddr),
        .wdata (al_wdata),
        .raddr (raddr),
        .rdata (al_rd)
    );

    assign result.valid            = ov_reg;
    assign result.status           = ost_reg;
    assign result.sequence_process = oseq_reg;
    assign result.last_result      = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            ret_reg     <= IDLE;
            pc_reg      <= PcWidth'(16);
            rc_reg      <= RcWidth'(8);
            for (int k = 0; k < MAX_RESOURCES; k++)
            begin
                avail_reg[k]  <= '0;
                staged_reg[k] <= '0;
                work_reg[k]   <= '0;
            end
            fin_reg     <= '0;
            mvld_reg    <= '0;
            avld_reg    <= '0;
            commit_reg  <= 1'b0;
            cpass_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            ov_reg      <= 1'b0;
            i_reg       <= '0;
            done_reg    <= '0;
            idle_reg    <= '0;
            rcnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_PROCESS_COUNT)
                    pc_reg <= wr_data;
                else
                    rc_reg <= wr_data[RcWidth-1:0];
            end

            if (emit_go)
                ov_reg <= 1'b1;
            else if (result.ready)
                ov_reg <= 1'b0;

            if (max_we)
                mvld_reg[waddr] <= 1'b1;
            if (al_we)
                avld_reg[waddr] <= 1'b1;

            // consume the table word returned for the previous issue
            pend_reg <= (state_reg == S_PASS) || (state_reg == C_PASS);
            if (pend_reg)
            begin
                if (cpass_reg)
                begin
                    if (staged_reg[pend_r_reg] > need_v)
                        exc_reg <= 1'b1;
                    if (staged_reg[pend_r_reg] > avail_reg[pend_r_reg])
                        wt_reg <= 1'b1;
                    oldal_reg[pend_r_reg] <= al_v;
                    newal_reg[pend_r_reg] <= al_v + staged_reg[pend_r_reg];
                end
                else
                begin
                    if (need_v > work_reg[pend_r_reg])
                        fit_reg <= 1'b0;
                    tmp_reg[pend_r_reg] <= sum_v[CW] ? '1 : sum_v[CW-1:0];
                end
            end

            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        p_reg       <= item.process;
                        em_st_reg   <= bad ? ST_BAD : ST_LOADED;
                        em_seq_reg  <= '0;
                        em_last_reg <= 1'b1;
                        ret_reg     <= IDLE;
                        if (bad)
                        begin
                            state_reg <= EMIT;
                        end
                        else if (item.operation == OP_SAFETY)
                        begin
                            commit_reg <= 1'b0;
                            state_reg  <= S_INIT;
                        end
                        else if (item.operation == OP_COMMIT)
                        begin
                            exc_reg   <= 1'b0;
                            wt_reg    <= 1'b0;
                            cpass_reg <= 1'b1;
                            rcnt_reg  <= '0;
                            state_reg <= C_PASS;
                        end
                        else
                        begin
                            if (item.operation == OP_LOAD_AVAIL)
                                avail_reg[RW'(item.resource)] <= amt_cw;
                            if (item.operation == OP_STAGE)
                                staged_reg[RW'(item.resource)] <= amt_cw;
                            state_reg <= EMIT;
                        end
                    end
                end

                EMIT:
                begin
                    // hold until the result register is free
                    if (emit_go)
                    begin
                        ost_reg   <= em_st_reg;
                        oseq_reg  <= em_seq_reg;
                        olast_reg <= em_last_reg;
                        state_reg <= ret_reg;
                    end
                end

                S_INIT:
                begin
                    for (int k = 0; k < MAX_RESOURCES; k++)
                        work_reg[k] <= avail_reg[k];
                    fin_reg   <= '0;
                    i_reg     <= '0;
                    done_reg  <= '0;
                    idle_reg  <= '0;
                    state_reg <= S_VISIT;
                end

                S_VISIT:
                begin
                    if (done_reg == n_eff || idle_reg == n_eff)
                        state_reg <= S_END;
                    else if (fin_reg[i_reg])
                    begin
                        idle_reg  <= idle_reg + NW'(1);
                        i_reg     <= (int'(i_reg) + 1 == int'(n_eff)) ? '0 : i_reg + PW'(1);
                    end
                    else
                    begin
                        fit_reg   <= 1'b1;
                        rcnt_reg  <= '0;
                        state_reg <= S_PASS;
                    end
                end

                S_PASS, C_PASS:
                begin
                    pend_r_reg  <= rcnt_reg;
                    pend_mv_reg <= mvld_reg[raddr];
                    pend_av_reg <= avld_reg[raddr];
                    rcnt_reg    <= rcnt_reg + RW'(1);
                    if (last_issue)
                        state_reg <= (state_reg == S_PASS) ? S_DRAIN : C_DRAIN;
                end

                S_DRAIN:
                    state_reg <= S_DECIDE;

                S_DECIDE:
                begin
                    i_reg <= (int'(i_reg) + 1 == int'(n_eff)) ? '0 : i_reg + PW'(1);
                    if (fit_reg)
                    begin
                        for (int k = 0; k < MAX_RESOURCES; k++)
                            if (k < int'(m_eff))
                                work_reg[k] <= tmp_reg[k];
                        fin_reg[i_reg] <= 1'b1;
                        done_reg       <= done_reg + NW'(1);
                        idle_reg       <= '0;
                        if (!commit_reg)
                        begin
                            em_st_reg   <= ST_SAFE;
                            em_seq_reg  <= ProcWidth'(i_reg);
                            em_last_reg <= (int'(done_reg) + 1 == int'(n_eff));
                            ret_reg     <= S_VISIT;
                            state_reg   <= EMIT;
                        end
                        else
                            state_reg <= S_VISIT;
                    end
                    else
                    begin
                        idle_reg  <= idle_reg + NW'(1);
                        state_reg <= S_VISIT;
                    end
                end

                S_END:
                begin
                    em_seq_reg  <= '0;
                    em_last_reg <= 1'b1;
                    ret_reg     <= IDLE;
                    if (!commit_reg)
                    begin
                        em_st_reg <= ST_UNSAFE;
                        state_reg <= (done_reg == n_eff) ? IDLE : EMIT;
                    end
                    else if (done_reg == n_eff)
                    begin
                        em_st_reg <= ST_GRANTED;
                        state_reg <= EMIT;
                    end
                    else
                    begin
                        // roll the grant back
                        for (int k = 0; k < MAX_RESOURCES; k++)
                            if (k < int'(m_eff))
                                avail_reg[k] <= avail_reg[k] + staged_reg[k];
                        rcnt_reg  <= '0;
                        state_reg <= R_WR;
                    end
                end

                C_DRAIN:
                    state_reg <= C_DECIDE;

                C_DECIDE:
                begin
                    cpass_reg   <= 1'b0;
                    em_seq_reg  <= '0;
                    em_last_reg <= 1'b1;
                    ret_reg     <= IDLE;
                    rcnt_reg    <= '0;
                    if (exc_reg)
                    begin
                        em_st_reg <= ST_EXCEEDS;
                        state_reg <= EMIT;
                    end
                    else if (wt_reg)
                    begin
                        em_st_reg <= ST_WAIT;
                        state_reg <= EMIT;
                    end
                    else
                    begin
                        for (int k = 0; k < MAX_RESOURCES; k++)
                            if (k < int'(m_eff))
                                avail_reg[k] <= avail_reg[k] - staged_reg[k];
                        state_reg <= C_WR;
                    end
                end

                C_WR:
                begin
                    rcnt_reg <= rcnt_reg + RW'(1);
                    if (last_issue)
                    begin
                        commit_reg <= 1'b1;
                        state_reg  <= S_INIT;
                    end
                end

                R_WR:
                begin
                    rcnt_reg <= rcnt_reg + RW'(1);
                    if (last_issue)
                    begin
                        em_st_reg <= ST_DENIED;
                        state_reg <= EMIT;
                    end
                end

                default:
                    state_reg <= IDLE;
            endcase
        end
    end
endmodule

>>> bench/testbench.sv
// Testbench: checks the banker's deadlock-avoidance block against its own predictor.
`timescale 1ns / 1ps

module testbench;
    import bda_pkg::*;

    // Operation codes the block does not define; it must answer them as bad index.
    localparam logic [OpWidth-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OpWidth-1:0] OP_SPARE_HI = 3'd7;
    // Cycles with no transaction on either channel before the run is abandoned.
    // The slowest check is 16*16 visits, so this leaves a wide margin.
    localparam int STALL_LIMIT = 40000;
    // Worst-case safety check plus commit overhead, used before register writes.
    localparam int SETTLE_CYCLES = 3000;

    typedef struct packed {
        logic [StatusWidth-1:0] status;
        logic [ProcWidth-1:0]   sequence_process;
        logic                   last_result;
    } bank_result_t;

    // Holds its own copy of the tables and the queue of results still owed.
    class bank_scoreboard;
        int unsigned    proc_reg;
        int unsigned    res_reg;
        logic [15:0]    avail_units [8];
        logic [15:0]    claim_tab   [16][8];
        logic [15:0]    held_tab    [16][8];
        logic [15:0]    request_buf [8];
        logic [15:0]    work_buf    [8];
        bit             done_flag   [16];
        int             finish_order[16];
        bank_result_t   owed[$];
        int             mismatches;

        function new();
            proc_reg = 16;
            res_reg = 8;
            mismatches = 0;
            foreach (avail_units[r])
            begin
                avail_units[r] = '0;
                request_buf[r] = '0;
                work_buf[r] = '0;
            end
            foreach (claim_tab[p, r])
            begin
                claim_tab[p][r] = '0;
                held_tab[p][r] = '0;
            end
            foreach (done_flag[p])
                done_flag[p] = 1'b0;
        endfunction

        function int unsigned live_procs();
            if (proc_reg < 1)
                return 1;
            return (proc_reg > 16) ? 16 : proc_reg;
        endfunction

        function int unsigned live_res();
            if (res_reg < 1)
                return 1;
            return (res_reg > 8) ? 8 : res_reg;
        endfunction

        function void write_reg(logic idx, logic [PcWidth-1:0] val);
            if (idx == REG_PROCESS_COUNT)
                proc_reg = val;
            else
                res_reg = val & 5'd15;
        endfunction

        function logic [15:0] need(int p, int r);
            return (claim_tab[p][r] > held_tab[p][r]) ? claim_tab[p][r] - held_tab[p][r] : '0;
        endfunction

        // Visit processes round-robin, finishing any whose need fits; give the count finished.
        function int safety_pass();
            int n, m, done, idle, i;
            bit fits;
            logic [16:0] sum;
            n = live_procs();
            m = live_res();
            done = 0;
            idle = 0;
            i = 0;
            work_buf = avail_units;
            foreach (done_flag[p])
                done_flag[p] = 1'b0;
            while (done < n && idle < n)
            begin
                fits = !done_flag[i];
                for (int r = 0; r < m; r++)
                    if (fits && need(i, r) > work_buf[r])
                        fits = 1'b0;
                if (fits)
                begin
                    for (int r = 0; r < m; r++)
                    begin
                        sum = {1'b0, work_buf[r]} + {1'b0, held_tab[i][r]};
                        work_buf[r] = sum[16] ? 16'hFFFF : sum[15:0];
                    end
                    done_flag[i] = 1'b1;
                    finish_order[done] = i;
                    done++;
                    idle = 0;
                end
                else
                    idle++;
                i = (i + 1) % n;
            end
            return done;
        endfunction

        function void owe(logic [StatusWidth-1:0] st, int seq, bit last);
            bank_result_t e;
            e.status = st;
            e.sequence_process = seq[ProcWidth-1:0];
            e.last_result = last;
            owed.push_back(e);
        endfunction

        // Note an accepted transaction and queue the results it must cause.
        function void note_item(logic [OpWidth-1:0] op, int p, int r, logic [15:0] amt);
            int n, m, cnt;
            n = live_procs();
            m = live_res();
            case (op)
                OP_LOAD_AVAIL, OP_LOAD_MAX, OP_LOAD_ALLOC:
                begin
                    if (r >= m || (op != OP_LOAD_AVAIL && p >= n))
                        owe(ST_BAD, 0, 1);
                    else
                    begin
                        if (op == OP_LOAD_AVAIL)
                            avail_units[r] = amt;
                        else if (op == OP_LOAD_MAX)
                            claim_tab[p][r] = amt;
                        else
                            held_tab[p][r] = amt;
                        owe(ST_LOADED, 0, 1);
                    end
                end
                OP_SAFETY:
                begin
                    cnt = safety_pass();
                    for (int k = 0; k < cnt; k++)
                        owe(ST_SAFE, finish_order[k], cnt == n && k + 1 == cnt);
                    if (cnt < n)
                        owe(ST_UNSAFE, 0, 1);
                end
                OP_STAGE:
                begin
                    if (r >= m)
                        owe(ST_BAD, 0, 1);
                    else
                    begin
                        request_buf[r] = amt;
                        owe(ST_LOADED, 0, 1);
                    end
                end
                OP_COMMIT:
                begin
                    if (p >= n)
                        owe(ST_BAD, 0, 1);
                    else
                        commit(p);
                end
                default:
                    owe(ST_BAD, 0, 1);
            endcase
        endfunction

        function void commit(int p);
            int m;
            m = live_res();
            for (int k = 0; k < m; k++)
                if (request_buf[k] > need(p, k))
                begin
                    owe(ST_EXCEEDS, 0, 1);
                    return;
                end
            for (int k = 0; k < m; k++)
                if (request_buf[k] > avail_units[k])
                begin
                    owe(ST_WAIT, 0, 1);
                    return;
                end
            for (int k = 0; k < m; k++)
            begin
                avail_units[k] -= request_buf[k];
                held_tab[p][k] += request_buf[k];
            end
            if (safety_pass() == live_procs())
            begin
                owe(ST_GRANTED, 0, 1);
                return;
            end
            // Roll back the tentative grant.
            for (int k = 0; k < m; k++)
            begin
                avail_units[k] += request_buf[k];
                held_tab[p][k] -= request_buf[k];
            end
            owe(ST_DENIED, 0, 1);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_result(bank_result_t got);
            bank_result_t want;
            if (owed.size() == 0)
            begin
                report("unexpected result, status", got.status, -1);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.sequence_process !== want.sequence_process)
                report("sequence_process", got.sequence_process, want.sequence_process);
            if (got.last_result !== want.last_result)
                report("last_result", got.last_result, want.last_result);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_index;
    logic [PcWidth-1:0] wr_data;

    bda_item_if   item_ch();
    bda_result_if result_ch();

    bankers_deadlock_avoidance dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    bank_scoreboard ledger;
    int sender_gap_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Stall the result channel at random, at the rate the current phase sets.
    always @(negedge clk)
        result_ch.ready = ($urandom_range(99) >= receiver_stall_pct);

    // Check every result transaction and watch for a hang on both channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                ledger.check_result({result_ch.status, result_ch.sequence_process,
                                     result_ch.last_result});
            if ((result_ch.valid && result_ch.ready) || (item_ch.valid && item_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Present one item, hold it until taken, then note it with the predictor.
    task send_item(logic [OpWidth-1:0] op, int p, int r, logic [15:0] amt);
        while ($urandom_range(99) < sender_gap_pct)
            @(negedge clk);
        item_ch.valid = 1'b1;
        item_ch.operation = op;
        item_ch.process = p[ProcWidth-1:0];
        item_ch.resource = r[ResWidth-1:0];
        item_ch.amount = amt;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        ledger.note_item(op, p, r, amt);
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    task drain();
        while (ledger.owed.size() != 0)
            @(negedge clk);
    endtask

    // Write one register once the block has gone quiet.
    task write_reg(logic idx, logic [PcWidth-1:0] val);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        ledger.write_reg(idx, val);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    function logic [15:0] pick_amount(int small_top);
        if ($urandom_range(99) < 75)
            return $urandom_range(small_top);
        return $urandom_range(65535);
    endfunction

    // Mostly in-range indexes so sequences get past the bad-index path.
    function int pick_proc();
        if ($urandom_range(99) < 90)
            return $urandom_range(ledger.live_procs() - 1);
        return $urandom_range(15);
    endfunction

    function int pick_res();
        if ($urandom_range(99) < 90)
            return $urandom_range(ledger.live_res() - 1);
        return $urandom_range(7);
    endfunction

    // One random step: a staged request with its commit, a check, a load, or noise.
    task random_step(output int used);
        int pick, m;
        pick = $urandom_range(99);
        m = ledger.live_res();
        used = 1;
        if (pick < 30)
        begin
            for (int r = 0; r < m; r++)
                send_item(OP_STAGE, $urandom_range(15), r, $urandom_range(3));
            send_item(OP_COMMIT, pick_proc(), $urandom_range(7), $urandom_range(65535));
            used = m + 1;
        end
        else if (pick < 45)
            send_item(OP_SAFETY, $urandom_range(15), $urandom_range(7), $urandom_range(65535));
        else if (pick < 60)
            send_item(OP_LOAD_AVAIL, $urandom_range(15), pick_res(), pick_amount(24));
        else if (pick < 75)
            send_item(OP_LOAD_MAX, pick_proc(), pick_res(), pick_amount(6));
        else if (pick < 90)
            send_item(OP_LOAD_ALLOC, pick_proc(), pick_res(), pick_amount(4));
        else if (pick < 96)
            send_item(OP_STAGE, $urandom_range(15), pick_res(), pick_amount(8));
        else
            send_item($urandom_range(7), $urandom_range(15), $urandom_range(7),
                      $urandom_range(65535));
    endtask

    int phase_procs [8] = '{16, 4, 1, 0, 31, 7, 16, 2};
    int phase_res   [8] = '{8, 3, 1, 0, 15, 8, 1, 5};

    initial
    begin
        int sent, used;
        ledger = new();
        quiet_cycles = 0;
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = 1'b0;
        wr_data = '0;
        item_ch.valid = 1'b0;
        item_ch.operation = OP_LOAD_AVAIL;
        item_ch.process = '0;
        item_ch.resource = '0;
        item_ch.amount = '0;
        result_ch.ready = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset counts: denial with rollback, grant, exceeds need,
        // must wait, unsafe and safe checks, saturating work, unknown operations.
        send_item(OP_LOAD_AVAIL, 0, 0, 16'd1);
        send_item(OP_LOAD_MAX, 0, 0, 16'd2);
        send_item(OP_LOAD_MAX, 1, 0, 16'd2);
        send_item(OP_STAGE, 9, 0, 16'd1);
        send_item(OP_COMMIT, 0, 0, 16'd0);
        send_item(OP_SAFETY, 0, 0, 16'd0);
        send_item(OP_LOAD_AVAIL, 0, 0, 16'd3);
        send_item(OP_COMMIT, 0, 0, 16'd0);
        send_item(OP_SAFETY, 15, 7, 16'hFFFF);
        send_item(OP_STAGE, 0, 0, 16'd0);
        send_item(OP_STAGE, 0, 7, 16'hFFFF);
        send_item(OP_COMMIT, 15, 7, 16'd0);
        send_item(OP_LOAD_MAX, 15, 7, 16'hFFFF);
        send_item(OP_COMMIT, 15, 0, 16'd0);
        send_item(OP_LOAD_AVAIL, 0, 7, 16'hFFFF);
        send_item(OP_LOAD_ALLOC, 5, 7, 16'hFFFF);
        send_item(OP_LOAD_ALLOC, 6, 7, 16'h8000);
        send_item(OP_SAFETY, 0, 0, 16'd0);
        send_item(OP_COMMIT, 15, 0, 16'd0);
        send_item(OP_SAFETY, 0, 0, 16'd0);
        send_item(OP_SPARE_LO, 15, 7, 16'hFFFF);
        send_item(OP_SPARE_HI, 0, 0, 16'd0);

        // Random part: each phase its own counts and idling pattern.
        sent = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_PROCESS_COUNT, phase_procs[ph]);
            write_reg(REG_RESOURCE_COUNT, phase_res[ph]);
            case (ph % 4)
                0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_gap_pct = 52; receiver_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_gap_pct = 24; receiver_stall_pct = 24; end
            endcase
            while (sent < (ph + 1) * 48)
            begin
                random_step(used);
                sent += used;
                // Hold the sender once until every owed result has come.
                if (ph == 5 && sent >= ph * 48 + 24 && sent < ph * 48 + 24 + used)
                    drain();
            end
        end

        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (ledger.mismatches == 0 && ledger.owed.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/bda_pkg.sv
hw/rtl/bda_ifs.sv
hw/rtl/bda_ram.sv
hw/rtl/bankers_deadlock_avoidance.sv
bench/testbench.sv
